FILE: rtl/core/carn_pkg.sv
package carn_pkg;

  // valid year range
  localparam logic [11:0] YearMin = 12'd1900;
  localparam logic [11:0] YearMax = 12'd2099;

  // gauss constants for the gregorian calendar
  localparam logic [8:0] GaussM = 9'd24;
  localparam logic [7:0] GaussN = 8'd5;

  // days counted back from easter sunday
  localparam logic [6:0] ShroveBack = 7'd47;
  localparam logic [6:0] FatThuBack = 7'd52;

  // mode codes
  localparam logic ModeShrove = 1'b0;
  localparam logic ModeFatThu = 1'b1;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;      // capture year and mode
    logic mod_step;  // year mod 19 and mod 7
    logic d_step;    // d term
    logic e_step;    // e term
    logic doy_step;  // easter and day of year minus offset
    logic res_step;  // write the result register
  } carn_cmd_t;

endpackage

FILE: rtl/core/carn_dp.sv
module carn_dp import carn_pkg::*; (
  input  logic        clk_i,
  input  carn_cmd_t   cmd_i,
  input  logic [11:0] year_i,
  input  logic        mode_i,
  output logic [4:0]  day_o,
  output logic [1:0]  month_o,
  output logic        year_out_of_range_o
);

  // v mod 19 for 8-bit v: reciprocal estimate then one correction
  function automatic logic [4:0] mod19(input logic [7:0] v);
    logic [12:0] p;
    logic [4:0]  q;
    logic [7:0]  r;
    p = {5'd0, v} * 13'd13;
    q = p[12:8];
    r = v - ({3'd0, q} * 8'd19);
    if (r >= 8'd19) begin
      r = r - 8'd19;
    end
    return r[4:0];
  endfunction

  // v mod 7 for 9-bit v
  function automatic logic [2:0] mod7(input logic [8:0] v);
    logic [15:0] p;
    logic [6:0]  q;
    logic [8:0]  r;
    p = {7'd0, v} * 16'd73;
    q = p[15:9];
    r = v - ({2'd0, q} * 9'd7);
    if (r >= 9'd7) begin
      r = r - 9'd7;
    end
    return r[2:0];
  endfunction

  // v mod 30 for 9-bit v
  function automatic logic [4:0] mod30(input logic [8:0] v);
    logic [13:0] p;
    logic [4:0]  q;
    logic [8:0]  r;
    p = {5'd0, v} * 14'd17;
    q = p[13:9];
    r = v - ({4'd0, q} * 9'd30);
    if (r >= 9'd30) begin
      r = r - 9'd30;
    end
    return r[4:0];
  endfunction

  logic [11:0] year_q;
  logic        mode_q;
  logic        oor_q;
  logic        leap_q;
  logic [4:0]  a_q;
  logic [2:0]  c_q;
  logic [4:0]  d_q;
  logic [2:0]  e_q;
  logic [6:0]  t_q;
  logic [4:0]  day_q;
  logic [1:0]  month_q;
  logic        flag_q;

  logic [7:0]  yoff;
  logic [8:0]  d_arg;
  logic [8:0]  e_arg;
  logic [4:0]  feb;
  logic [5:0]  s;
  logic [4:0]  eday;
  logic        emar;
  logic [6:0]  doy;
  logic [6:0]  back;

  // year offset from the start of the valid range; not masked, out-of-range years are zeroed at the result step
  assign yoff  = 8'(year_q - YearMin);
  assign d_arg = ({4'd0, a_q} * 9'd19) + GaussM;
  assign e_arg = {6'd0, year_q[1:0], 1'b0} + {4'd0, c_q, 2'b00}
               + ({4'd0, d_q} * 9'd6) + {1'b0, GaussN};
  assign feb   = leap_q ? 5'd29 : 5'd28;
  assign s     = {1'b0, d_q} + {3'd0, e_q};
  assign back  = (mode_q == ModeFatThu) ? FatThuBack : ShroveBack;

  // easter sunday with the two april exceptions
  always_comb begin
    emar = (s < 6'd10);
    if (emar) begin
      eday = 5'(s + 6'd22);
    end else begin
      eday = 5'(s - 6'd9);
      if (eday == 5'd26) begin
        eday = 5'd19;
      end
      if (eday == 5'd25 && d_q == 5'd28 && e_q == 3'd6 && a_q > 5'd10) begin
        eday = 5'd18;
      end
    end
    doy = 7'd31 + {2'd0, feb} + (emar ? {2'd0, eday} : 7'd31 + {2'd0, eday});
  end

  // step registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      year_q <= year_i;
      mode_q <= mode_i;
      oor_q  <= (year_i < YearMin) || (year_i > YearMax);
      // within range only 2000 is a century leap year, 1900 is not
      leap_q <= (year_i[1:0] == 2'd0) && (year_i != YearMin);
    end
    if (cmd_i.mod_step) begin
      a_q <= mod19(yoff);
      // the range starts at 3 mod 7
      c_q <= mod7({1'b0, yoff} + 9'd3);
    end
    if (cmd_i.d_step) begin
      d_q <= mod30(d_arg);
    end
    if (cmd_i.e_step) begin
      e_q <= mod7(e_arg);
    end
    if (cmd_i.doy_step) begin
      t_q <= doy - back;
    end
    if (cmd_i.res_step) begin
      flag_q <= oor_q;
      if (oor_q) begin
        day_q   <= 5'd0;
        month_q <= 2'd0;
      end else if (t_q <= 7'd31) begin
        day_q   <= t_q[4:0];
        month_q <= 2'd1;
      end else if (t_q <= 7'd31 + {2'd0, feb}) begin
        day_q   <= 5'(t_q - 7'd31);
        month_q <= 2'd2;
      end else begin
        day_q   <= 5'(t_q - 7'd31 - {2'd0, feb});
        month_q <= 2'd3;
      end
    end
  end

  assign day_o               = day_q;
  assign month_o             = month_q;
  assign year_out_of_range_o = flag_q;

endmodule

FILE: rtl/core/carn_ctrl.sv
module carn_ctrl import carn_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output carn_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    StIdle,
    StMod,
    StD,
    StE,
    StDoy,
    StRes
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   res_go;

  // result may be written once the output register is free or draining
  assign res_go = (state_q == StRes) && (!out_valid_q || out_ready_i);

  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = in_valid_i && (state_q == StIdle);
    cmd_o.mod_step = (state_q == StMod);
    cmd_o.d_step   = (state_q == StD);
    cmd_o.e_step   = (state_q == StE);
    cmd_o.doy_step = (state_q == StDoy);
    cmd_o.res_step = res_go;
  end

  // sequencer and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            state_q <= StMod;
          end
        end
        StMod: state_q <= StD;
        StD:   state_q <= StE;
        StE:   state_q <= StDoy;
        StDoy: state_q <= StRes;
        StRes: begin
          if (res_go) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
      if (res_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/core/carnival_date_from_year_unit.sv
// Carnival date unit: takes a Gregorian year and a mode and returns the day and month of
// Shrove Tuesday (mode 0, Easter minus 47 days) or Fat Thursday (mode 1, minus 52 days),
// with Easter found by the Gauss method (M = 24, N = 5) and its April exceptions. Years
// outside 1900 to 2099 give day 0, month 0 and the out-of-range flag. One item is worked
// at a time through a five-step sequencer (mod 19 and mod 7, d, e, day of year, month
// split); the result step waits while an earlier result is still unread. The result
// sits in an output register, so the next item is taken while an earlier result still
// waits to be read.
module carnival_date_from_year_unit import carn_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [11:0] year_i,
  input  logic        mode_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [4:0]  day_o,
  output logic [1:0]  month_o,
  output logic        year_out_of_range_o
);

  carn_cmd_t cmd;

  // sequencer
  carn_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // arithmetic steps and result register
  carn_dp u_dp (
    .clk_i               (clk_i),
    .cmd_i               (cmd),
    .year_i              (year_i),
    .mode_i              (mode_i),
    .day_o               (day_o),
    .month_o             (month_o),
    .year_out_of_range_o (year_out_of_range_o)
  );

endmodule

FILE: rtl/core/carn_checker.sv
module carn_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [11:0] year_i,
  input logic        mode_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [4:0]  day_o,
  input logic [1:0]  month_o,
  input logic        year_out_of_range_o
);

  // a waiting input item holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(year_i) && $stable(mode_i))
    else $error("input item changed while waiting");

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(day_o) && $stable(month_o)
      && $stable(year_out_of_range_o))
    else $error("result changed while stalled");

  // out-of-range items carry a zero date
  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && year_out_of_range_o |-> day_o == 5'd0 && month_o == 2'd0)
    else $error("out-of-range item with a date");

  // in-range items fall in january to march on a real day
  a_date_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !year_out_of_range_o |-> month_o != 2'd0 && day_o != 5'd0)
    else $error("in-range item without a date");

  // busy for the next cycle after an item is taken
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second item taken too soon");

endmodule

bind carnival_date_from_year_unit carn_checker u_carn_checker (.*);
